// File: rtl/rset_pkg.sv
// ----------------------------------------------------------------------------
// rset_pkg
// Shared types and constants for the randomized set table.
// ----------------------------------------------------------------------------
package rset_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int DRAW_W   = 16;
    localparam int ACT_W    = 2;
    localparam int ERR_W    = 2;
    localparam int PROD_W   = DRAW_W + CNT_W;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PICK   = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [VALUE_W-1:0] value;
        logic [DRAW_W-1:0]         random_draw;
    } req_t;

    typedef struct packed {
        logic                      success;
        logic signed [VALUE_W-1:0] picked_value;
        logic [ERR_W-1:0]          error;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic             busy;
    } stat_t;

endpackage

// File: rtl/rset_core.sv
// ----------------------------------------------------------------------------
// rset_core
// Entry store and sequencer: linear search, compacting shift and pick read.
// ----------------------------------------------------------------------------
module rset_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  rset_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output rset_pkg::res_t res,
    output rset_pkg::stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PICK_MUL,
        ST_PICK_RD,
        ST_PICK_DATA,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    logic [rset_pkg::CNT_W-1:0]          count_reg;
    logic [rset_pkg::CNT_W-1:0]          idx_reg;
    logic [rset_pkg::IDX_W-1:0]          lag_idx_reg;
    logic                                lag_valid_reg;
    logic [rset_pkg::ACT_W-1:0]          action_reg;
    logic signed [rset_pkg::VALUE_W-1:0] value_reg;
    logic [rset_pkg::DRAW_W-1:0]         draw_reg;
    logic                                success_reg;
    logic signed [rset_pkg::VALUE_W-1:0] picked_reg;
    logic [rset_pkg::ERR_W-1:0]          error_reg;

    logic signed [rset_pkg::VALUE_W-1:0] mem [rset_pkg::CAPACITY];
    logic signed [rset_pkg::VALUE_W-1:0] rd_data_reg;
    logic [rset_pkg::IDX_W-1:0]          rd_addr;
    logic                                mem_we;
    logic [rset_pkg::IDX_W-1:0]          wr_addr;
    logic signed [rset_pkg::VALUE_W-1:0] wr_data;

    logic                                hit;
    logic                                more;
    logic [rset_pkg::PROD_W-1:0]         product;

    // The word read in the previous cycle is compared against the key.
    assign hit     = lag_valid_reg && (rd_data_reg == value_reg);
    assign more    = idx_reg < count_reg;
    assign rd_addr = idx_reg[rset_pkg::IDX_W-1:0];
    assign product = rset_pkg::PROD_W'(draw_reg) * rset_pkg::PROD_W'(count_reg);

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = lag_idx_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            ST_SCAN: begin
                if (action_reg == rset_pkg::ACT_INSERT && !hit && !more && !lag_valid_reg
                    && count_reg != rset_pkg::CAP_CNT) begin
                    mem_we  = 1'b1;
                    wr_addr = count_reg[rset_pkg::IDX_W-1:0];
                    wr_data = value_reg;
                end
            end
            ST_SHIFT: begin
                mem_we = lag_valid_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lag_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        action_reg    <= req.action;
                        value_reg     <= req.value;
                        draw_reg      <= req.random_draw;
                        idx_reg       <= '0;
                        lag_valid_reg <= 1'b0;
                        success_reg   <= 1'b0;
                        picked_reg    <= '0;
                        error_reg     <= rset_pkg::ERR_NONE;
                        case (req.action) inside
                            rset_pkg::ACT_INSERT, rset_pkg::ACT_REMOVE: begin
                                state_reg <= ST_SCAN;
                            end
                            rset_pkg::ACT_PICK: begin
                                if (count_reg == '0) begin
                                    error_reg <= rset_pkg::ERR_EMPTY;
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_PICK_MUL;
                                end
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        lag_valid_reg <= 1'b0;
                        if (action_reg == rset_pkg::ACT_REMOVE) begin
                            idx_reg   <= rset_pkg::CNT_W'(lag_idx_reg) + 1'b1;
                            state_reg <= ST_SHIFT;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else if (more) begin
                        lag_valid_reg <= 1'b1;
                        lag_idx_reg   <= idx_reg[rset_pkg::IDX_W-1:0];
                        idx_reg       <= idx_reg + 1'b1;
                    end else if (lag_valid_reg) begin
                        lag_valid_reg <= 1'b0;
                    end else begin
                        // Key is absent.
                        if (action_reg == rset_pkg::ACT_INSERT) begin
                            if (count_reg == rset_pkg::CAP_CNT) begin
                                error_reg <= rset_pkg::ERR_FULL;
                            end else begin
                                count_reg   <= count_reg + 1'b1;
                                success_reg <= 1'b1;
                            end
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_SHIFT: begin
                    // Read entry i while entry i-2 takes the word read last cycle.
                    if (more) begin
                        lag_valid_reg <= 1'b1;
                        lag_idx_reg   <= rset_pkg::IDX_W'(idx_reg - 1'b1);
                        idx_reg       <= idx_reg + 1'b1;
                    end else if (lag_valid_reg) begin
                        lag_valid_reg <= 1'b0;
                    end else begin
                        count_reg   <= count_reg - 1'b1;
                        success_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_PICK_MUL: begin
                    idx_reg   <= product[rset_pkg::PROD_W-1:rset_pkg::DRAW_W];
                    state_reg <= ST_PICK_RD;
                end
                ST_PICK_RD: begin
                    state_reg <= ST_PICK_DATA;
                end
                ST_PICK_DATA: begin
                    picked_reg  <= rd_data_reg;
                    success_reg <= 1'b1;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready        = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_DONE);
    assign res.success      = success_reg;
    assign res.picked_value = picked_reg;
    assign res.error        = error_reg;
    assign stat.entry_count = count_reg;
    assign stat.busy        = (state_reg != ST_IDLE);

endmodule

// File: rtl/randomized_set_table.sv
// ----------------------------------------------------------------------------
// randomized_set_table
// Set of distinct 32-bit values with insert, remove and random pick.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one request per word: s_tuser holds the action
//   (insert, remove, pick), s_tdata the value and the random draw. The master
//   stream returns exactly one result word per request, in request order:
//   m_tuser holds success and the error code, m_tdata the picked value.
//   An insert or a remove takes the sequencer through a linear search of the
//   stored entries, one entry per cycle over a single read port. An insert,
//   or a remove that misses, loads its result once the search ends. A remove
//   that hits stops searching at the matching entry and then shifts the later
//   entries down through the same port. A pick on a non-empty table steps
//   through a multiply, a memory read and a data capture. The sequencer
//   returns to idle before it takes the next request. s_tready is high only
//   while the sequencer is idle.
//   Results land in an output register; the next request is accepted while
//   a result waits there, and a stalled m_tready holds the word in place.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module randomized_set_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] value, [47:32] random_draw
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] picked_value
    output logic [2:0]  m_tuser    // [0] success, [2:1] error
);

    rset_pkg::req_t  req;
    rset_pkg::res_t  res;
    rset_pkg::stat_t stat;
    logic            res_valid;
    logic            res_ready;

    logic                                out_valid_reg;
    logic                                out_success_reg;
    logic signed [rset_pkg::VALUE_W-1:0] out_picked_reg;
    logic [rset_pkg::ERR_W-1:0]          out_error_reg;

    assign req.action      = s_tuser;
    assign req.value       = s_tdata[31:0];
    assign req.random_draw = s_tdata[47:32];

    rset_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .stat      (stat)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg   <= 1'b1;
            out_success_reg <= res.success;
            out_picked_reg  <= res.picked_value;
            out_error_reg   <= res.error;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_picked_reg;
    assign m_tuser  = {out_error_reg, out_success_reg};

    // The count never runs past the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.entry_count <= rset_pkg::CAP_CNT)
        else $error("entry count above capacity");

    // The count moves by at most one per cycle.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.entry_count != $past(stat.entry_count)) |->
        (stat.entry_count == $past(stat.entry_count) + 1'b1 ||
         stat.entry_count == $past(stat.entry_count) - 1'b1))
        else $error("entry count jumped");

    // A result word that carries an error never reports success.
    a_error_no_success: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] != rset_pkg::ERR_NONE) |-> !m_tuser[0])
        else $error("error and success together");

    // A request is only taken while no result is pending in the sequencer.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!res_valid && !stat.busy))
        else $error("request accepted while busy");

    // A changed count only shows while the sequencer holds a result ready.
    a_count_at_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.entry_count != $past(stat.entry_count)) |-> res_valid)
        else $error("entry count changed outside completion");

endmodule
